// File: rtl/bmhq_pkg.sv
// shared types, field widths and codes for the binary min-heap queue
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY_DEF = 255;
  localparam int KEY_W        = 32;
  localparam int TAG_W        = 16;
  localparam int COUNT_W      = 8;
  localparam int STATUS_W     = 2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]    out_tag;
    logic [COUNT_W-1:0]  count;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/binary_min_heap_queue_unit.sv
// top level of the binary min-heap priority queue
//
// input channel in_valid / in_ready / in_data carries one word per item:
// mode 0 inserts (key, tag), mode 1 removes and returns the minimum.
// output channel out_valid / out_ready / out_data returns one word per item
// with status, the removed key and tag (zero unless a delete succeeded) and
// the entry count after the item.
// one registered read port and one shared key comparator under a sequencer;
// in_ready stays low while an item is worked through; its steps:
//   insert: the new key rises a level per step while strictly below its parent
//   delete: the root is read out, the last entry moves to the root and
//   sinks a level per step while its smaller child is not above it
// errors (delete when empty, insert when full) go straight to the result.
// the result sits in an output register, so the next word is taken while
// a result waits; if the receiver stalls, a second finished result holds
// the core and in_ready stays low until out_ready returns.
// reset empties the heap at once; the slot store is not cleared, since a
// slot is always written before it is read.
`default_nettype none

module binary_min_heap_queue_unit import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  res_t      res;
  logic      res_take;
  logic      slot_free;
  logic      out_valid_r;
  out_word_t out_data_r;

  bmhq_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res      (res),
    .res_take (res_take)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign res_take  = res.valid && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/bmhq_cmp.sv
// shared unsigned key comparator used by every sift step
`default_nettype none

module bmhq_cmp import bmhq_pkg::*; (
  input  wire logic [KEY_W-1:0] a,
  input  wire logic [KEY_W-1:0] b,
  output logic                  lt
);

  assign lt = (a < b);

endmodule

`default_nettype wire

// File: rtl/bmhq_core.sv
// heap store and sift sequencer for insert and delete-min
`default_nettype none

module bmhq_core import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output res_t          res,
  input  wire logic     res_take
);

  localparam int AW = $clog2(CAPACITY + 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_UP_ISS  = 10'b00_0000_0010,
    S_UP_CMP  = 10'b00_0000_0100,
    S_DN_ROOT = 10'b00_0000_1000,
    S_DN_LAST = 10'b00_0001_0000,
    S_DN_L    = 10'b00_0010_0000,
    S_DN_R    = 10'b00_0100_0000,
    S_DN_DEC  = 10'b00_1000_0000,
    S_PUT     = 10'b01_0000_0000,
    S_FIN     = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [AW:0]         child_r, child_nxt;
  entry_t              mv_r, mv_nxt;
  entry_t              ck_r, ck_nxt;
  entry_t              rk_r, rk_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  entry_t              heap_mem [CAPACITY+1];
  entry_t              rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;

  logic [KEY_W-1:0]    cmp_a, cmp_b;
  logic                cmp_lt;
  logic [AW:0]         cnt_ext;
  logic [AW:0]         child_dbl;
  logic [AW+7:0]       cnt_wide;

  bmhq_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign cnt_ext   = {1'b0, cnt_r};
  assign child_dbl = child_r << 1;
  assign cnt_wide  = {8'd0, cnt_r};

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    child_nxt  = child_r;
    mv_nxt     = mv_r;
    ck_nxt     = ck_r;
    rk_nxt     = rk_r;
    status_nxt = status_r;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = mv_r;
    cmp_a      = mv_r.key;
    cmp_b      = ck_r.key;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mv_nxt     = '{key: in_data.key, tag: in_data.tag};
          rk_nxt     = '0;
          status_nxt = ST_DONE;
          if (in_data.mode == MODE_INSERT) begin
            if (cnt_r == AW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              cnt_nxt   = cnt_r + AW'(1);
              pos_nxt   = cnt_r + AW'(1);
              state_nxt = S_UP_ISS;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              rd_addr   = AW'(1);
              state_nxt = S_DN_ROOT;
            end
          end
        end
      end
      S_UP_ISS: begin
        if (pos_r == AW'(1)) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_addr   = pos_r >> 1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_a = mv_r.key;
        cmp_b = rd_data_r.key;
        wr_en = 1'b1;
        if (cmp_lt) begin
          // parent moves down one level
          wr_data   = rd_data_r;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UP_ISS;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_ROOT: begin
        rk_nxt    = rd_data_r;
        rd_addr   = cnt_r;
        cnt_nxt   = cnt_r - AW'(1);
        state_nxt = S_DN_LAST;
      end
      S_DN_LAST: begin
        mv_nxt    = rd_data_r;
        pos_nxt   = AW'(1);
        child_nxt = (AW+1)'(2);
        if ((AW+1)'(2) <= cnt_ext) begin
          rd_addr   = AW'(2);
          state_nxt = S_DN_L;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = AW'(1);
          wr_data   = rd_data_r;
          state_nxt = S_FIN;
        end
      end
      S_DN_L: begin
        ck_nxt = rd_data_r;
        if (child_r < cnt_ext) begin
          rd_addr   = child_r[AW-1:0] + AW'(1);
          state_nxt = S_DN_R;
        end else begin
          state_nxt = S_DN_DEC;
        end
      end
      S_DN_R: begin
        // right child wins only when strictly below the left one
        cmp_a = rd_data_r.key;
        cmp_b = ck_r.key;
        if (cmp_lt) begin
          ck_nxt    = rd_data_r;
          child_nxt = child_r + (AW+1)'(1);
        end
        state_nxt = S_DN_DEC;
      end
      S_DN_DEC: begin
        cmp_a = mv_r.key;
        cmp_b = ck_r.key;
        wr_en = 1'b1;
        if (cmp_lt) begin
          state_nxt = S_FIN;
        end else begin
          wr_data   = ck_r;
          pos_nxt   = child_r[AW-1:0];
          child_nxt = child_dbl;
          if (child_dbl <= cnt_ext) begin
            rd_addr   = child_dbl[AW-1:0];
            state_nxt = S_DN_L;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end
      S_PUT: begin
        wr_en     = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    child_r  <= child_nxt;
    mv_r     <= mv_nxt;
    ck_r     <= ck_nxt;
    rk_r     <= rk_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= heap_mem[rd_addr];
  end

  assign in_ready         = (state_r == S_IDLE);
  assign res.valid        = (state_r == S_FIN);
  assign res.word.status  = status_r;
  assign res.word.out_key = rk_r.key;
  assign res.word.out_tag = rk_r.tag;
  assign res.word.count   = cnt_wide[7:0];

endmodule

`default_nettype wire

// File: rtl/bmhq_checker.sv
// port-level checks for the heap queue, bound to the top level
`default_nettype none

module bmhq_checker import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  localparam logic [15:0] CAP_W = 16'(CAPACITY);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // in_ready drops after every accepted item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |->
      out_data.out_key == '0 && out_data.out_tag == '0)
    else $error("error word carries a key or tag");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.count == CAP_W[7:0])
    else $error("full status with wrong count");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.count == '0)
    else $error("empty status with nonzero count");

endmodule

bind binary_min_heap_queue_unit bmhq_checker #(
  .CAPACITY (CAPACITY)
) u_bmhq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
